>>> hdl/pcnms_pkg.sv
//------------------------------------------------------------------------------
// pcnms_pkg
// Shared types and constants of the per-class box suppression block.
//------------------------------------------------------------------------------
package pcnms_pkg;

  localparam int MAX_DETS    = 64;
  localparam int MAX_CLASSES = 128;
  localparam int IDX_W       = $clog2(MAX_DETS);
  localparam int CNT_W       = $clog2(MAX_DETS + 1);

  localparam logic [0:0] CFG_THRESH  = 1'b0;
  localparam logic [0:0] CFG_CLASSES = 1'b1;

  typedef struct packed {
    logic [6:0]  class_id;
    logic [15:0] score;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic        last_in;
  } in_req_t;

  typedef struct packed {
    logic [6:0]  out_class;
    logic [15:0] out_score;
    logic [15:0] out_center_x;
    logic [15:0] out_center_y;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic        last_out;
    logic        overflow;
  } out_req_t;

  // controller to datapath commands
  typedef struct packed {
    logic             store_wr;   // write the input request at the fill count
    logic             clr_set;    // empty the store for the next set
    logic             sort_rd;    // read entries i and j for the sort compare
    logic             sort_swap;  // swap order slots j and j-1
    logic             pair_rd;    // read order[i] and order[j] for iou
    logic             pair_eval;  // iou result valid, suppress if needed
    logic             emit_rd;    // read the kept entry
    logic             emit_load;  // load the output register
    logic             emit_last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             swap_need;  // order[j] goes before order[j-1]
    logic             same_class; // order[i] and order[j] share a class
    logic             sup_i;      // order[i] suppressed
    logic             sup_j;
    logic             out_busy;
  } stat_t;

endpackage

>>> hdl/pcnms_iou.sv
//------------------------------------------------------------------------------
// pcnms_iou
// Pipelined overlap test of two boxes, three register stages.
//------------------------------------------------------------------------------
module pcnms_iou (
  input  logic        clk,
  input  logic [63:0] box_a,
  input  logic [63:0] box_b,
  input  logic [15:0] thresh,
  output logic        hit
);
  import pcnms_pkg::*;

  logic signed [18:0] l1, r1, l2, r2, t1, d1, t2, d2, lox, hix, loy, hiy;
  logic [17:0] ix_r, iy_r;
  logic        pos_r;
  logic [15:0] aw_r, ah_r, bw_r, bh_r;
  logic [35:0] i4_r;
  logic [32:0] area_r;
  logic        pos2_r;
  logic [35:0] u4;

  // doubled edges
  always_comb begin
    l1 = 19'(signed'({2'b0, box_a[15:0], 1'b0})) - 19'(signed'({3'b0, box_a[47:32]}));
    r1 = 19'(signed'({2'b0, box_a[15:0], 1'b0})) + 19'(signed'({3'b0, box_a[47:32]}));
    l2 = 19'(signed'({2'b0, box_b[15:0], 1'b0})) - 19'(signed'({3'b0, box_b[47:32]}));
    r2 = 19'(signed'({2'b0, box_b[15:0], 1'b0})) + 19'(signed'({3'b0, box_b[47:32]}));
    t1 = 19'(signed'({2'b0, box_a[31:16], 1'b0})) - 19'(signed'({3'b0, box_a[63:48]}));
    d1 = 19'(signed'({2'b0, box_a[31:16], 1'b0})) + 19'(signed'({3'b0, box_a[63:48]}));
    t2 = 19'(signed'({2'b0, box_b[31:16], 1'b0})) - 19'(signed'({3'b0, box_b[63:48]}));
    d2 = 19'(signed'({2'b0, box_b[31:16], 1'b0})) + 19'(signed'({3'b0, box_b[63:48]}));
    lox = (l1 > l2) ? l1 : l2;
    hix = (r1 < r2) ? r1 : r2;
    loy = (t1 > t2) ? t1 : t2;
    hiy = (d1 < d2) ? d1 : d2;
  end

  // stage 1: overlap extents
  always_ff @(posedge clk) begin
    pos_r <= (hix > lox) && (hiy > loy);
    ix_r  <= 18'(hix - lox);
    iy_r  <= 18'(hiy - loy);
    aw_r  <= box_a[47:32];
    ah_r  <= box_a[63:48];
    bw_r  <= box_b[47:32];
    bh_r  <= box_b[63:48];
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    pos2_r <= pos_r;
    i4_r   <= 36'(ix_r * iy_r);
    area_r <= 33'(aw_r * ah_r) + 33'(bw_r * bh_r);
  end

  // stage 3: cross-multiplied compare
  assign u4 = {1'b0, area_r, 2'b0} - i4_r;
  always_ff @(posedge clk) begin
    hit <= pos2_r && ({i4_r, 16'b0} > 52'(thresh * u4));
  end
endmodule

>>> hdl/pcnms_dp.sv
//------------------------------------------------------------------------------
// pcnms_dp
// Datapath: detection stores, order table, suppress mask, output register.
//------------------------------------------------------------------------------
module pcnms_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pcnms_pkg::in_req_t  in_data,
  input  logic                in_keep,
  input  logic                in_ovf,
  input  logic [15:0]         thresh,
  input  pcnms_pkg::cmd_t     cmd,
  output pcnms_pkg::stat_t    stat,
  output logic                out_valid,
  input  logic                out_stall,
  output pcnms_pkg::out_req_t out_data
);
  import pcnms_pkg::*;

  logic [63:0]      box_mem [MAX_DETS];
  logic [22:0]      sc_mem  [MAX_DETS];
  logic [IDX_W-1:0] order_r [MAX_DETS];
  logic [MAX_DETS-1:0] sup_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic [63:0]      box_a_r, box_b_r;
  logic [22:0]      sc_a_r, sc_b_r;
  logic [IDX_W-1:0] ia_r, ib_r, ib_d1_r, ib_d2_r, ib_d3_r;
  logic             hit;
  logic             ov_r;
  out_req_t         od_r;

  // store write and paired reads through the order table
  always_ff @(posedge clk) begin
    if (cmd.store_wr && in_keep) begin
      box_mem[cnt_r[IDX_W-1:0]] <= {in_data.box_height, in_data.box_width,
                                    in_data.center_y, in_data.center_x};
      sc_mem[cnt_r[IDX_W-1:0]]  <= {in_data.class_id, in_data.score};
    end
    box_a_r <= box_mem[order_r[cmd.i]];
    sc_a_r  <= sc_mem[order_r[cmd.i]];
    box_b_r <= box_mem[order_r[cmd.j]];
    sc_b_r  <= sc_mem[order_r[cmd.j]];
    ia_r    <= order_r[cmd.i];
    ib_r    <= order_r[cmd.j];
    ib_d1_r <= ib_r;
    ib_d2_r <= ib_d1_r;
    ib_d3_r <= ib_d2_r;
  end

  // fill count, overflow flag and suppress mask
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_set) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      sup_r <= '0;
    end else begin
      if (cmd.store_wr && in_keep) cnt_r <= cnt_r + 1'b1;
      if (cmd.store_wr && in_ovf)  ovf_r <= 1'b1;
      if (cmd.pair_eval && hit)    sup_r[ib_d3_r] <= 1'b1;
    end
  end

  // order table: identity fill on each load, swap during insertion sort
  // (ia_r and ib_r hold slots j-1 and j as read for the compare)
  always_ff @(posedge clk) begin
    if (cmd.store_wr && in_keep) order_r[cnt_r[IDX_W-1:0]] <= cnt_r[IDX_W-1:0];
    if (cmd.sort_swap) begin
      order_r[cmd.j]        <= ia_r;
      order_r[cmd.j - 1'b1] <= ib_r;
    end
  end

  pcnms_iou u_iou (
    .clk   (clk),
    .box_a (box_a_r),
    .box_b (box_b_r),
    .thresh(thresh),
    .hit   (hit)
  );

  // sort compare: a is slot j-1 (read on port i), b is slot j
  always_comb begin
    stat.count      = cnt_r;
    stat.same_class = sc_a_r[22:16] == sc_b_r[22:16];
    stat.swap_need  = (sc_b_r[22:16] < sc_a_r[22:16]) ||
                      (stat.same_class && (sc_b_r[15:0] > sc_a_r[15:0])) ||
                      (stat.same_class && (sc_b_r[15:0] == sc_a_r[15:0]) && (ib_r < ia_r));
    stat.sup_i      = sup_r[ia_r];
    stat.sup_j      = sup_r[ib_r];
    stat.out_busy   = ov_r && out_stall;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_load) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
    if (cmd.emit_load) begin
      od_r <= '{out_class: sc_a_r[22:16], out_score: sc_a_r[15:0],
                out_center_x: box_a_r[15:0], out_center_y: box_a_r[31:16],
                out_width: box_a_r[47:32], out_height: box_a_r[63:48],
                last_out: cmd.emit_last, overflow: ovf_r};
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

>>> hdl/pcnms_ctrl.sv
//------------------------------------------------------------------------------
// pcnms_ctrl
// Controller: load, insertion sort, greedy pairwise pass, emit.
//------------------------------------------------------------------------------
module pcnms_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_last,
  input  pcnms_pkg::stat_t stat,
  output pcnms_pkg::cmd_t  cmd
);
  import pcnms_pkg::*;

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_SRD   = 11'b00000000010,
    S_SCMP  = 11'b00000000100,
    S_ARD   = 11'b00000001000,
    S_ACHK  = 11'b00000010000,
    S_BRD   = 11'b00000100000,
    S_BCHK  = 11'b00001000000,
    S_WAIT  = 11'b00010000000,
    S_ERD   = 11'b00100000000,
    S_EMIT  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, n_r, n_nxt, w_r, w_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;   // order slot of the kept box not yet sent
  logic             emitted_r, emitted_nxt;
  logic             acc;

  assign in_stall = (st_r != S_LOAD);
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
    end else begin
      st_r <= st_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; n_r <= n_nxt; w_r <= w_nxt;
    k_r <= k_nxt; emitted_r <= emitted_nxt;
  end

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; n_nxt = n_r; w_nxt = w_r;
    k_nxt = k_r; emitted_nxt = emitted_r;
    cmd = '0;
    cmd.i = i_r[IDX_W-1:0];
    cmd.j = j_r[IDX_W-1:0];
    unique case (st_r)
      // accept loads; last one starts the sort after its store write lands
      S_LOAD: begin
        cmd.store_wr = acc;
        if (acc && in_last) begin
          st_nxt = S_SRD; i_nxt = CNT_W'(1); j_nxt = CNT_W'(1);
        end
      end
      // insertion sort: j walks down from i, compare slots j-1 and j
      S_SRD: begin
        n_nxt = stat.count;
        if (i_r >= stat.count) begin
          st_nxt = S_ARD; i_nxt = '0; emitted_nxt = 1'b0;
        end else begin
          cmd.i = IDX_W'(j_r - 1'b1);
          st_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (stat.swap_need) begin
          cmd.sort_swap = 1'b1;
          if (j_r == CNT_W'(1)) begin
            i_nxt = i_r + 1'b1; j_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r - 1'b1;
          end
        end else begin
          i_nxt = i_r + 1'b1; j_nxt = i_r + 1'b1;
        end
        st_nxt = S_SRD;
      end
      // pick next unsuppressed anchor i; at the end read the pending box
      S_ARD: begin
        if (i_r >= n_r) begin
          cmd.i = k_r[IDX_W-1:0];
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat.sup_i) begin
          i_nxt = i_r + 1'b1; st_nxt = S_ARD;
        end else begin
          j_nxt = i_r + 1'b1; st_nxt = S_BRD;
        end
      end
      // compare anchor against later same-class entries
      S_BRD: begin
        if (j_r >= n_r) begin
          st_nxt = S_WAIT; w_nxt = CNT_W'(3);
        end else begin
          st_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (!stat.same_class) begin
          st_nxt = S_WAIT; w_nxt = CNT_W'(3);
        end else begin
          cmd.pair_rd = 1'b1;
          st_nxt = S_WAIT; w_nxt = CNT_W'(3);
          j_nxt = j_r;
        end
      end
      // drain the iou pipe; on a real compare suppress, then move on
      S_WAIT: begin
        w_nxt = w_r - 1'b1;
        if (w_r == CNT_W'(1)) begin
          cmd.pair_eval = (j_r < n_r) && !stat.sup_j && stat.same_class;
          if ((j_r < n_r) && stat.same_class) begin
            j_nxt = j_r + 1'b1; st_nxt = S_BRD;
          end else begin
            st_nxt = S_ERD;
          end
        end
      end
      // anchor kept: send the previous kept box, this one becomes pending
      S_ERD: begin
        if (emitted_r) begin
          cmd.i = k_r[IDX_W-1:0];
          st_nxt = S_EMIT;
        end else begin
          k_nxt = i_r;
          emitted_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
          st_nxt = S_ARD;
        end
      end
      S_EMIT: begin
        cmd.i = k_r[IDX_W-1:0];
        if (!stat.out_busy) begin
          k_nxt = i_r;
          st_nxt = S_ARD;
          i_nxt = i_r + 1'b1;
          cmd.emit_load = 1'b1;
          cmd.emit_last = 1'b0;
        end
      end
      // send the pending box flagged last, then empty the store
      S_DONE: begin
        cmd.i = k_r[IDX_W-1:0];
        if (!emitted_r || !stat.out_busy) begin
          cmd.emit_load = emitted_r;
          cmd.emit_last = emitted_r;
          cmd.clr_set = 1'b1;
          st_nxt = S_LOAD;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end
endmodule

>>> hdl/per_class_box_nms.sv
//------------------------------------------------------------------------------
// per_class_box_nms
// Per-class greedy box suppression with an integer iou test.
//------------------------------------------------------------------------------
// Usage: detections enter on the in_ channel one request per cycle while
// loading. The request with last_in set starts the pass: in_stall stays high
// until the last kept box of the set has been loaded into the output
// register. The store holds 64 entries and is emptied after each set; loads
// past that are dropped and flagged. Sorting is an insertion sort over
// the n stored detections. The greedy pass waits on the three-stage iou
// multiplier pipe for each compared pair and skips suppressed anchors.
// A kept box is sent once the next kept box is found or the set ends, so the
// final one carries last_out. Each kept box leaves through an output
// register; out_stall holds that register and the controller waits.
// Reset clears the fill count, flags and controller and restores the
// threshold and class-count registers. overflow marks sets in which loads
// were dropped.
//------------------------------------------------------------------------------
module per_class_box_nms (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcnms_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcnms_pkg::out_req_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import pcnms_pkg::*;

  logic [15:0] thresh_r;
  logic [7:0]  ncls_r;
  logic        keep, ovf;
  cmd_t        cmd;
  stat_t       stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 16'd29491;
      ncls_r   <= 8'd80;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESH:  thresh_r <= cfg_data;
        CFG_CLASSES: ncls_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // class filter and store-full check
  always_comb begin
    keep = ({1'b0, in_data.class_id} < ncls_r) && (stat.count < CNT_W'(MAX_DETS));
    ovf  = ({1'b0, in_data.class_id} < ncls_r) && (stat.count >= CNT_W'(MAX_DETS));
  end

  pcnms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_last(in_data.last_in), .stat(stat), .cmd(cmd)
  );

  pcnms_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_keep(keep), .in_ovf(ovf),
    .thresh(thresh_r), .cmd(cmd), .stat(stat), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data)
  );

  // no loads taken while a set is being worked on
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> !cmd.store_wr)
    else $error("store written during pass");
  // sort swap and iou evaluation never coincide
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd.sort_swap && cmd.pair_eval))
    else $error("sort and pass overlap");
  // an emit never overwrites a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data.out_score))
    else $error("result changed under stall");
endmodule
